### design/sebc_pkg.sv
// ---------------------------------------------------------------------------
// sebc_pkg: shared definitions for the spi serial eeprom backup chip
// Command codes, bus opcodes, state encodings, store request type and the
// size, page and protection helpers used by the control path.
// ---------------------------------------------------------------------------
`default_nettype none

package sebc_pkg;

  // backing store geometry
  localparam int MEM_BYTES = 131072;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int ADDR_W    = 24;
  localparam int PADDR_W   = 3;

  // bus event opcodes
  localparam logic [1:0] OP_XFER     = 2'd0;
  localparam logic [1:0] OP_SELECT   = 2'd1;
  localparam logic [1:0] OP_DESELECT = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WREN  = 8'h06;

  // protection modes
  localparam logic [1:0] PROT_NONE    = 2'd0;
  localparam logic [1:0] PROT_QUARTER = 2'd1;
  localparam logic [1:0] PROT_HALF    = 2'd2;
  localparam logic [1:0] PROT_ALL     = 2'd3;

  // size codes
  localparam logic [1:0] SIZE_8K   = 2'd0;
  localparam logic [1:0] SIZE_32K  = 2'd1;
  localparam logic [1:0] SIZE_64K  = 2'd2;
  localparam logic [1:0] SIZE_128K = 2'd3;

  // register word select (paddr bit 2)
  localparam logic REG_SIZE_CODE = 1'b0;
  localparam logic REG_FRAM_MODE = 1'b1;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // transaction phase, one-hot
  typedef enum logic [9:0] {
    PH_DESELECTED = 10'b00_0000_0001,
    PH_COMMAND    = 10'b00_0000_0010,
    PH_RDSR       = 10'b00_0000_0100,
    PH_WRSR       = 10'b00_0000_1000,
    PH_ADDR0      = 10'b00_0001_0000,
    PH_ADDR1      = 10'b00_0010_0000,
    PH_ADDR2      = 10'b00_0100_0000,
    PH_READ       = 10'b00_1000_0000,
    PH_WRITE      = 10'b01_0000_0000,
    PH_IDLE       = 10'b10_0000_0000
  } phase_t;

  // last command taken
  typedef enum logic [2:0] {
    LC_NONE  = 3'd0,
    LC_WREN  = 3'd1,
    LC_WRDI  = 3'd2,
    LC_RDSR  = 3'd3,
    LC_WRSR  = 3'd4,
    LC_READ  = 3'd5,
    LC_WRITE = 3'd6,
    LC_OTHER = 3'd7
  } last_cmd_t;

  // request to the backing store
  typedef struct packed {
    logic              re;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } store_req_t;

  // device size in bytes
  function automatic logic [ADDR_W-1:0] dev_bytes(input logic [1:0] size_code);
    logic [ADDR_W-1:0] b;
    case (size_code)
      SIZE_8K:   b = ADDR_W'(8192);
      SIZE_32K:  b = ADDR_W'(32768);
      SIZE_64K:  b = ADDR_W'(65536);
      SIZE_128K: b = ADDR_W'(131072);
      default:   b = ADDR_W'(8192);
    endcase
    return b;
  endfunction

  // address mask for the store, limited to the physical array
  function automatic logic [ADDR_W-1:0] dev_mask(input logic [1:0] size_code);
    return (dev_bytes(size_code) - ADDR_W'(1)) & ADDR_W'(MEM_BYTES - 1);
  endfunction

  // page wrap mask; fram mode spans the whole device
  function automatic logic [ADDR_W-1:0] page_wrap_mask(input logic [1:0] size_code,
                                                       input logic       fram_mode);
    logic [ADDR_W-1:0] m;
    if (fram_mode) begin
      m = dev_bytes(size_code) - ADDR_W'(1);
    end else begin
      case (size_code)
        SIZE_8K:   m = ADDR_W'(31);
        SIZE_32K:  m = ADDR_W'(63);
        SIZE_64K:  m = ADDR_W'(127);
        SIZE_128K: m = ADDR_W'(255);
        default:   m = ADDR_W'(31);
      endcase
    end
    return m;
  endfunction

  // block protection test on the address reduced to the device
  function automatic logic write_blocked(input logic [1:0]        size_code,
                                         input logic [1:0]        prot,
                                         input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] a;
    logic              blk;
    bytes = dev_bytes(size_code);
    a     = addr & (bytes - ADDR_W'(1));
    case (prot)
      PROT_QUARTER: blk = (a >= (bytes - (bytes >> 2)));
      PROT_HALF:    blk = (a >= (bytes >> 1));
      PROT_ALL:     blk = 1'b1;
      default:      blk = 1'b0;
    endcase
    return blk;
  endfunction

endpackage

`default_nettype wire

### design/sebc_store.sv
// ---------------------------------------------------------------------------
// sebc_store: byte-wide backing store with power-up fill
// After reset a sweep writes 0xFF to every byte, one per cycle, while busy
// is high. Then one read or one write per cycle; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sebc_store (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sebc_pkg::store_req_t  req,
  output logic                       busy,
  output logic [7:0]                 rd_data
);

  localparam logic [sebc_pkg::MEM_AW-1:0] LAST_ADDR =
    sebc_pkg::MEM_AW'(sebc_pkg::MEM_BYTES - 1);

  logic [7:0]                  mem_r [sebc_pkg::MEM_BYTES];
  logic                        clr_busy_r;
  logic [sebc_pkg::MEM_AW-1:0] clr_addr_r;
  logic [7:0]                  rd_data_r;
  logic                        wr_en;
  logic [sebc_pkg::MEM_AW-1:0] wr_addr;
  logic [7:0]                  wr_data;

  // fill sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + sebc_pkg::MEM_AW'(1);
    end
  end

  // write port: sweep has priority, no requests arrive while busy
  always_comb begin
    wr_en   = clr_busy_r | req.we;
    wr_addr = clr_busy_r ? clr_addr_r : req.addr;
    wr_data = clr_busy_r ? sebc_pkg::IDLE_BYTE : req.wdata;
  end

  // array access
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign busy    = clr_busy_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/spi_eeprom_backup_chip.sv
// ---------------------------------------------------------------------------
// spi_eeprom_backup_chip: spi serial eeprom / fram model, 8K to 128K bytes
// Takes one bus event per transfer (select, deselect, byte) and returns the
// byte driven on miso. Standard 25xx command set with block protection.
// ---------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | in_opcode[1:0], in_mosi_byte[7:0]
//  out      | out_valid / out_stall  | out_miso_byte[7:0]
//  config   | psel/penable/pwrite    | paddr[2:0], pwdata, prdata
//
//  One event per cycle while in_stall is low; its result appears in the cycle after the transfer.
//  The rate is set by the single store port: one read or write per event.
//  After reset the store fills all MEM_BYTES (131072) bytes with 0xFF;
//  in_stall stays high meanwhile, register writes are taken as usual.
//  A stalled result holds the one output slot; in_stall follows out_stall
//  only while that slot is full.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_eeprom_backup_chip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // event channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [7:0]                    in_mosi_byte,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_miso_byte,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sebc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW = sebc_pkg::ADDR_W;

  // registers
  logic [1:0]          size_code_r;
  logic                fram_mode_r;
  sebc_pkg::phase_t    phase_r,      phase_nxt;
  sebc_pkg::last_cmd_t last_cmd_r,   last_cmd_nxt;
  logic [AW-1:0]       byte_addr_r,  byte_addr_nxt;
  logic                wel_r,        wel_nxt;
  logic [1:0]          prot_r,       prot_nxt;
  logic                swd_r,        swd_nxt;
  logic                out_valid_r;
  logic                out_sel_mem_r, out_sel_mem_nxt;
  logic [7:0]          out_byte_r,   out_byte_nxt;

  // datapath
  logic                 in_fire;
  logic                 cfg_wr;
  logic                 store_busy;
  logic [7:0]           store_rd_data;
  sebc_pkg::store_req_t store_req;
  logic [AW-1:0]        pmask;
  logic [AW-1:0]        mem_addr_full;
  logic [7:0]           status_byte;
  sebc_pkg::phase_t     first_addr_ph;

  // handshake
  assign in_fire  = in_valid & ~in_stall;
  assign in_stall = store_busy | (out_valid_r & out_stall);
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_code_r <= sebc_pkg::SIZE_8K;
      fram_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        sebc_pkg::REG_SIZE_CODE: size_code_r <= pwdata[1:0];
        sebc_pkg::REG_FRAM_MODE: fram_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      sebc_pkg::REG_SIZE_CODE: prdata = {30'd0, size_code_r};
      sebc_pkg::REG_FRAM_MODE: prdata = {31'd0, fram_mode_r};
      default:                 prdata = '0;
    endcase
  end

  // derived values
  assign pmask         = sebc_pkg::page_wrap_mask(size_code_r, fram_mode_r);
  assign mem_addr_full = byte_addr_r & sebc_pkg::dev_mask(size_code_r);
  assign status_byte   = {swd_r, 3'b000, prot_r, wel_r, 1'b0};
  assign first_addr_ph = (size_code_r == sebc_pkg::SIZE_128K) ? sebc_pkg::PH_ADDR0
                                                               : sebc_pkg::PH_ADDR1;

  // event decode and transaction control
  always_comb begin
    phase_nxt       = phase_r;
    last_cmd_nxt    = last_cmd_r;
    byte_addr_nxt   = byte_addr_r;
    wel_nxt         = wel_r;
    prot_nxt        = prot_r;
    swd_nxt         = swd_r;
    out_sel_mem_nxt = 1'b0;
    out_byte_nxt    = sebc_pkg::IDLE_BYTE;
    store_req.re    = 1'b0;
    store_req.we    = 1'b0;
    store_req.addr  = mem_addr_full[sebc_pkg::MEM_AW-1:0];
    store_req.wdata = in_mosi_byte;

    if (in_fire) begin
      case (in_opcode)
        sebc_pkg::OP_XFER: begin
          case (phase_r)
            sebc_pkg::PH_COMMAND: begin
              case (in_mosi_byte)
                sebc_pkg::CMD_WREN: begin
                  last_cmd_nxt = sebc_pkg::LC_WREN;
                  wel_nxt      = 1'b1;
                  phase_nxt    = sebc_pkg::PH_IDLE;
                end
                sebc_pkg::CMD_WRDI: begin
                  last_cmd_nxt = sebc_pkg::LC_WRDI;
                  wel_nxt      = 1'b0;
                  phase_nxt    = sebc_pkg::PH_IDLE;
                end
                sebc_pkg::CMD_RDSR: begin
                  last_cmd_nxt = sebc_pkg::LC_RDSR;
                  phase_nxt    = sebc_pkg::PH_RDSR;
                end
                sebc_pkg::CMD_WRSR: begin
                  last_cmd_nxt = sebc_pkg::LC_WRSR;
                  phase_nxt    = wel_r ? sebc_pkg::PH_WRSR : sebc_pkg::PH_IDLE;
                end
                sebc_pkg::CMD_READ: begin
                  last_cmd_nxt  = sebc_pkg::LC_READ;
                  byte_addr_nxt = '0;
                  phase_nxt     = first_addr_ph;
                end
                sebc_pkg::CMD_WRITE: begin
                  last_cmd_nxt = sebc_pkg::LC_WRITE;
                  if (wel_r) begin
                    byte_addr_nxt = '0;
                    phase_nxt     = first_addr_ph;
                  end else begin
                    phase_nxt = sebc_pkg::PH_IDLE;
                  end
                end
                default: begin
                  last_cmd_nxt = sebc_pkg::LC_OTHER;
                  phase_nxt    = sebc_pkg::PH_IDLE;
                end
              endcase
            end
            sebc_pkg::PH_RDSR: begin
              out_byte_nxt = status_byte;
            end
            sebc_pkg::PH_WRSR: begin
              wel_nxt   = in_mosi_byte[1];
              prot_nxt  = in_mosi_byte[3:2];
              swd_nxt   = in_mosi_byte[7];
              phase_nxt = sebc_pkg::PH_IDLE;
            end
            sebc_pkg::PH_ADDR0: begin
              byte_addr_nxt = {in_mosi_byte, 16'h0000};
              phase_nxt     = sebc_pkg::PH_ADDR1;
            end
            sebc_pkg::PH_ADDR1: begin
              byte_addr_nxt = byte_addr_r | {8'h00, in_mosi_byte, 8'h00};
              phase_nxt     = sebc_pkg::PH_ADDR2;
            end
            sebc_pkg::PH_ADDR2: begin
              byte_addr_nxt = byte_addr_r | {16'h0000, in_mosi_byte};
              phase_nxt     = (last_cmd_r == sebc_pkg::LC_READ) ? sebc_pkg::PH_READ
                                                                : sebc_pkg::PH_WRITE;
            end
            sebc_pkg::PH_READ: begin
              store_req.re    = 1'b1;
              out_sel_mem_nxt = 1'b1;
              byte_addr_nxt   = byte_addr_r + AW'(1);
            end
            sebc_pkg::PH_WRITE: begin
              // blocked bytes are dropped and the address holds
              if (!sebc_pkg::write_blocked(size_code_r, prot_r, byte_addr_r)) begin
                store_req.we  = 1'b1;
                byte_addr_nxt = (byte_addr_r & ~pmask) | ((byte_addr_r + AW'(1)) & pmask);
              end
            end
            default: ;
          endcase
        end
        sebc_pkg::OP_SELECT: begin
          if (phase_r == sebc_pkg::PH_DESELECTED) begin
            phase_nxt = sebc_pkg::PH_COMMAND;
          end
        end
        sebc_pkg::OP_DESELECT: begin
          if (last_cmd_r == sebc_pkg::LC_WRITE || last_cmd_r == sebc_pkg::LC_WRSR) begin
            wel_nxt = 1'b0;
          end
          phase_nxt = sebc_pkg::PH_DESELECTED;
        end
        default: ;
      endcase
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sebc_pkg::PH_DESELECTED;
      last_cmd_r  <= sebc_pkg::LC_NONE;
      byte_addr_r <= '0;
      wel_r       <= 1'b0;
      prot_r      <= sebc_pkg::PROT_NONE;
      swd_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      last_cmd_r  <= last_cmd_nxt;
      byte_addr_r <= byte_addr_nxt;
      wel_r       <= wel_nxt;
      prot_r      <= prot_nxt;
      swd_r       <= swd_nxt;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_sel_mem_r <= out_sel_mem_nxt;
      out_byte_r    <= out_byte_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_miso_byte = out_sel_mem_r ? store_rd_data : out_byte_r;

  // backing store
  sebc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .busy    (store_busy),
    .rd_data (store_rd_data)
  );

endmodule

`default_nettype wire

### design/sebc_checker.sv
// ---------------------------------------------------------------------------
// sebc_checker: port-level checks for spi_eeprom_backup_chip
// Watches the event and result ports; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sebc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_opcode,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_miso_byte
);

  // a stalled result holds its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_miso_byte))
    else $error("stalled result changed");

  // every transfer produces a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer without result");

  // select, deselect and unused events return the idle byte
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode != sebc_pkg::OP_XFER
      |=> out_miso_byte == sebc_pkg::IDLE_BYTE)
    else $error("non-byte event returned data");

  // the single result slot back-pressures the input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result slot is full");

endmodule

bind spi_eeprom_backup_chip sebc_checker u_sebc_checker (.*);

`default_nettype wire
